FILE: hw/rtl/hsv2rgb_pkg.sv
// Shared constants and the scaling divider for the HSV to RGB converter.
`default_nettype none

package hsv2rgb_pkg;

  // Field widths
  localparam int HUE_W = 16;
  localparam int PCT_W = 7;
  localparam int LVL_W = 9;
  localparam int REM_W = 13;  // remainder within a sector, 0..5999
  localparam int PROD_W = 14; // 10000 and sector products
  localparam int NUM_W = 20;  // scaled numerators, up to 1000000
  localparam int SEC_W = 3;

  // Hue geometry
  localparam logic [HUE_W-1:0] HUE_CIRCLE  = 16'd36000;
  localparam logic [HUE_W-1:0] SECTOR_SPAN = 16'd6000;

  // Percent limits
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PROD_W-1:0] PCT_SQ  = 14'd10000;

  // rem / 60 == (rem >> 2) / 15, done as (x * 4370) >> 16, exact for rem < 6000
  localparam logic [12:0] FRAC_RECIP = 13'd4370;

  // floor(y / 15625) for y < 2^22 as (y * ceil(2^36 / 15625)) >> 36
  localparam int SCALE_SHIFT = 36;
  localparam logic [22:0] SCALE_RECIP = 23'd4398047;

  // Configuration register indexes
  localparam logic CFG_SAT = 1'b0;
  localparam logic CFG_VAL = 1'b1;

  // Hue sectors
  localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

  // Level = floor(numerator * 256 / 1000000) = floor(4 * numerator / 15625)
  function automatic logic [LVL_W-1:0] scale_level(input logic [NUM_W-1:0] num);
    logic [NUM_W+1:0] y;
    logic [44:0]      prod;
    y    = {num, 2'b00};
    prod = 45'(y) * 45'(SCALE_RECIP);
    return prod[SCALE_SHIFT+LVL_W-1:SCALE_SHIFT];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hsv_to_rgb_integer_unit.sv
// Top level: pipelined integer HSV to RGB converter.
`default_nettype none

// Converts one hue word per clock (hundredths of a degree, 36000 wraps to 0)
// into red, green and blue levels on a 0..256 scale, using the saturation and
// value percent registers (values above 100 act as 100). A hue is taken at
// every clock edge where start is high; busy is never raised. Each result
// appears on out_red/out_green/out_blue with out_valid high for one cycle,
// in input order. The seven register stages are: hue wrap, sector split,
// in-sector fraction, sector products, value products, scaling to 256, and
// channel select. Write the registers only while no hue is in flight.
module hsv_to_rgb_integer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Configuration
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [hsv2rgb_pkg::PCT_W-1:0]   cfg_data,
  // Input words
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [hsv2rgb_pkg::HUE_W-1:0]   in_hue,
  // Result words
  output logic                                 out_valid,
  output logic [hsv2rgb_pkg::LVL_W-1:0]        out_red,
  output logic [hsv2rgb_pkg::LVL_W-1:0]        out_green,
  output logic [hsv2rgb_pkg::LVL_W-1:0]        out_blue
);

  localparam int STAGES = 7;

  // Configuration registers
  logic [hsv2rgb_pkg::PCT_W-1:0] sat_r;
  logic [hsv2rgb_pkg::PCT_W-1:0] val_r;
  logic [hsv2rgb_pkg::PCT_W-1:0] sat_c;
  logic [hsv2rgb_pkg::PCT_W-1:0] val_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= hsv2rgb_pkg::PCT_FULL;
      val_r <= hsv2rgb_pkg::PCT_FULL;
    end else if (cfg_we) begin
      if (cfg_index == hsv2rgb_pkg::CFG_SAT) begin
        sat_r <= cfg_data;
      end else begin
        val_r <= cfg_data;
      end
    end
  end

  // Clamp to 100 percent
  assign sat_c = (sat_r > hsv2rgb_pkg::PCT_FULL) ? hsv2rgb_pkg::PCT_FULL : sat_r;
  assign val_c = (val_r > hsv2rgb_pkg::PCT_FULL) ? hsv2rgb_pkg::PCT_FULL : val_r;

  // Valid bits travel with the data
  logic [STAGES-1:0] vld_r;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], accept};
    end
  end

  // Stage 1: fold the hue into one turn
  logic [hsv2rgb_pkg::HUE_W-1:0] h1_nxt, h1_r;

  assign h1_nxt = (in_hue >= hsv2rgb_pkg::HUE_CIRCLE) ? in_hue - hsv2rgb_pkg::HUE_CIRCLE
                                                      : in_hue;

  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
  end

  // Stage 2: sector and remainder within it
  logic [hsv2rgb_pkg::SEC_W-1:0] sec2_nxt, sec2_r;
  logic [hsv2rgb_pkg::HUE_W-1:0] base2;
  logic [hsv2rgb_pkg::HUE_W-1:0] rem2_full;
  logic [hsv2rgb_pkg::REM_W-1:0] rem2_r;

  always_comb begin
    if (h1_r < 16'd6000) begin
      sec2_nxt = hsv2rgb_pkg::SEC_RED_YEL;
      base2    = 16'd0;
    end else if (h1_r < 16'd12000) begin
      sec2_nxt = hsv2rgb_pkg::SEC_YEL_GRN;
      base2    = hsv2rgb_pkg::SECTOR_SPAN;
    end else if (h1_r < 16'd18000) begin
      sec2_nxt = hsv2rgb_pkg::SEC_GRN_CYN;
      base2    = 16'd12000;
    end else if (h1_r < 16'd24000) begin
      sec2_nxt = hsv2rgb_pkg::SEC_CYN_BLU;
      base2    = 16'd18000;
    end else if (h1_r < 16'd30000) begin
      sec2_nxt = hsv2rgb_pkg::SEC_BLU_MAG;
      base2    = 16'd24000;
    end else begin
      sec2_nxt = hsv2rgb_pkg::SEC_MAG_RED;
      base2    = 16'd30000;
    end
  end

  assign rem2_full = h1_r - base2;

  always_ff @(posedge clk) begin
    sec2_r <= sec2_nxt;
    rem2_r <= rem2_full[hsv2rgb_pkg::REM_W-1:0];
  end

  // Stage 3: fraction 0..99 = rem / 60
  logic [hsv2rgb_pkg::SEC_W-1:0] sec3_r;
  logic [23:0]                   frac_prod;
  logic [hsv2rgb_pkg::PCT_W-1:0] f3_r;

  assign frac_prod = 24'(rem2_r[hsv2rgb_pkg::REM_W-1:2]) * 24'(hsv2rgb_pkg::FRAC_RECIP);

  always_ff @(posedge clk) begin
    sec3_r <= sec2_r;
    f3_r   <= frac_prod[22:16];
  end

  // Stage 4: 10000 - S*f, 10000 - S*(100-f), and 100*(100-S)
  logic [hsv2rgb_pkg::SEC_W-1:0]  sec4_r;
  logic [hsv2rgb_pkg::PCT_W-1:0]  sinv4;
  logic [hsv2rgb_pkg::PROD_W-1:0] sf4, sfi4;
  logic [hsv2rgb_pkg::PROD_W-1:0] aq4_r, at4_r, ap4_r;

  assign sinv4 = hsv2rgb_pkg::PCT_FULL - sat_c;
  assign sf4   = 14'(sat_c) * 14'(f3_r);
  assign sfi4  = 14'(sat_c) * 14'(hsv2rgb_pkg::PCT_FULL - f3_r);

  always_ff @(posedge clk) begin
    sec4_r <= sec3_r;
    aq4_r  <= hsv2rgb_pkg::PCT_SQ - sf4;
    at4_r  <= hsv2rgb_pkg::PCT_SQ - sfi4;
    ap4_r  <= 14'(sinv4) * 14'(hsv2rgb_pkg::PCT_FULL);
  end

  // Stage 5: multiply by value
  logic [hsv2rgb_pkg::SEC_W-1:0] sec5_r;
  logic [hsv2rgb_pkg::NUM_W-1:0] nq5_r, nt5_r, np5_r, nv5_r;

  always_ff @(posedge clk) begin
    sec5_r <= sec4_r;
    nq5_r  <= 20'(val_c) * 20'(aq4_r);
    nt5_r  <= 20'(val_c) * 20'(at4_r);
    np5_r  <= 20'(val_c) * 20'(ap4_r);
    nv5_r  <= 20'(val_c) * 20'(hsv2rgb_pkg::PCT_SQ);
  end

  // Stage 6: scale to 0..256
  logic [hsv2rgb_pkg::SEC_W-1:0] sec6_r;
  logic [hsv2rgb_pkg::LVL_W-1:0] q6_r, t6_r, p6_r, v6_r;

  always_ff @(posedge clk) begin
    sec6_r <= sec5_r;
    q6_r   <= hsv2rgb_pkg::scale_level(nq5_r);
    t6_r   <= hsv2rgb_pkg::scale_level(nt5_r);
    p6_r   <= hsv2rgb_pkg::scale_level(np5_r);
    v6_r   <= hsv2rgb_pkg::scale_level(nv5_r);
  end

  // Stage 7: route levels to channels by sector
  logic [hsv2rgb_pkg::LVL_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [hsv2rgb_pkg::LVL_W-1:0] red_r, green_r, blue_r;

  always_comb begin
    case (sec6_r)
      hsv2rgb_pkg::SEC_RED_YEL: begin
        red_nxt = v6_r; green_nxt = t6_r; blue_nxt = p6_r;
      end
      hsv2rgb_pkg::SEC_YEL_GRN: begin
        red_nxt = q6_r; green_nxt = v6_r; blue_nxt = p6_r;
      end
      hsv2rgb_pkg::SEC_GRN_CYN: begin
        red_nxt = p6_r; green_nxt = v6_r; blue_nxt = t6_r;
      end
      hsv2rgb_pkg::SEC_CYN_BLU: begin
        red_nxt = p6_r; green_nxt = q6_r; blue_nxt = v6_r;
      end
      hsv2rgb_pkg::SEC_BLU_MAG: begin
        red_nxt = t6_r; green_nxt = p6_r; blue_nxt = v6_r;
      end
      default: begin
        red_nxt = v6_r; green_nxt = p6_r; blue_nxt = q6_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`ifndef SYNTH
  // Every accepted hue comes out after the full pipeline depth
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_valid)
    else $error("result word missing after pipeline latency");

  // Levels never exceed full scale
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= 9'd256) && (out_green <= 9'd256) && (out_blue <= 9'd256))
    else $error("output level above full scale");

  // Zero saturation gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (sat_c == 7'd0)) |-> (out_red == out_green) && (out_green == out_blue))
    else $error("zero saturation did not give grey");
`endif

endmodule

`default_nettype wire
